>>> hdl/wheel_position_move_controller_defines.svh
// Assertion macros for the wheel position move controller.
// Used by the top level; needs nothing else.
`ifndef WHEEL_POSITION_MOVE_CONTROLLER_DEFINES_SVH
`define WHEEL_POSITION_MOVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WPMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wpmc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wpmc: next-cycle check failed");

`endif

>>> hdl/wpmc_pkg.sv
// Shared types and constants of the wheel position move controller.
// No dependencies; used by the channel interfaces and the top level.
package wpmc_pkg;

  // Request codes carried by an input beat
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_STOP   = 2'd2
  } action_e;

  // Move status reported with every result beat
  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_MOVING      = 3'd1,
    ST_REACHED     = 3'd2,
    ST_FAULT       = 3'd3,
    ST_MAGNET_LOST = 3'd4,
    ST_STALL       = 3'd5,
    ST_TIMEOUT     = 3'd6
  } status_e;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CREEP_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DUTY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CREEP_FWD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CREEP_REV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_MOVE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TMO    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR   = 3'd7;

  // Register reset values
  localparam logic [7:0]  RST_TOLERANCE    = 8'd3;
  localparam logic [10:0] RST_CREEP_THRESH = 11'd34;
  localparam logic [7:0]  RST_FAST_DUTY    = 8'd110;
  localparam logic [7:0]  RST_CREEP_FWD    = 8'd60;
  localparam logic [7:0]  RST_CREEP_REV    = 8'd60;
  localparam logic [7:0]  RST_STALL_MOVE   = 8'd2;
  localparam logic [15:0] RST_STALL_TMO    = 16'd800;
  localparam logic        RST_INVERT_DIR   = 1'b0;

  // Fixed field widths
  localparam int TMO_W  = 16;
  localparam int STEP_W = 10;
  localparam int DUTY_W = 8;

endpackage

>>> hdl/wpmc_channels.sv
// Valid/ready channel interfaces of the wheel position move controller:
// command input, result output and register write. Depends on wpmc_pkg.

// Command beats toward the controller
interface wpmc_in_if import wpmc_pkg::*; #(
  parameter int ANGLE_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [ANGLE_BITS-1:0] target_angle;
  logic [TMO_W-1:0]      move_limit_ms;
  logic [ANGLE_BITS-1:0] measured_angle;
  logic [STEP_W-1:0]     time_step_ms;
  logic                  driver_fault;
  logic                  magnet_present;

  modport source (
    output valid, action, target_angle, move_limit_ms, measured_angle,
           time_step_ms, driver_fault, magnet_present,
    input  ready
  );
  modport sink (
    input  valid, action, target_angle, move_limit_ms, measured_angle,
           time_step_ms, driver_fault, magnet_present,
    output ready
  );
endinterface

// Result beats from the controller
interface wpmc_out_if import wpmc_pkg::*; #(
  parameter int ANGLE_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic [DUTY_W-1:0]            drive_duty;
  logic                         drive_forward;
  logic                         brake_on;
  logic [2:0]                   move_status;
  logic signed [ANGLE_BITS-1:0] angle_error;

  modport source (
    output valid, drive_duty, drive_forward, brake_on, move_status, angle_error,
    input  ready
  );
  modport sink (
    input  valid, drive_duty, drive_forward, brake_on, move_status, angle_error,
    output ready
  );
endinterface

// Register write beats
interface wpmc_cfg_if import wpmc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

>>> hdl/wheel_position_move_controller.sv
// Wheel position move controller: two-speed bang-bang position loop with
// stall and timeout detection. Depends on wpmc_pkg, wpmc_channels.sv and
// wheel_position_move_controller_defines.svh.
//
// Usage:
//  - in_i carries command beats: start (target, timeout, first angle),
//    sample (measured angle, elapsed ms, fault and magnet flags) or stop.
//  - out_o returns exactly one result beat per command: duty, direction,
//    brake, move status and the wrapped angle error.
//  - cfg_i writes the eight tuning registers; always ready. Write only
//    while no command is in flight.
//  - A command is captured in an input register, evaluated
//    combinationally against the controller state and lands in the result
//    register, which drives out_o.valid and the result fields.
//  - Throughput is one command per cycle unless out_o stalls; the state update
//    is a single add/compare pass, so consecutive commands never wait on each other.
//  - When out_o stalls, one result waits in the result register and one
//    command in the input register; in_i.ready then drops until out_o
//    takes its beat.
//  - Reset clears the move, timers and held angles and loads the register
//    defaults; in_i.ready is high as soon as reset is released.
`include "wheel_position_move_controller_defines.svh"

module wheel_position_move_controller import wpmc_pkg::*; #(
  parameter int ANGLE_BITS = 12,
  parameter int TIMER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpmc_in_if.sink     in_i,
  wpmc_out_if.source  out_o,
  wpmc_cfg_if.sink    cfg_i
);

  localparam int MAG_W = (ANGLE_BITS > 11) ? ANGLE_BITS : 11;
  localparam int CMP_W = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;
  localparam int SUM_W = ((TIMER_BITS > STEP_W) ? TIMER_BITS : STEP_W) + 1;
  localparam logic [SUM_W-1:0] TMR_MAX = SUM_W'({TIMER_BITS{1'b1}});

  // Tuning registers
  logic [7:0]  tol_q;
  logic [10:0] creep_thr_q;
  logic [7:0]  fast_duty_q, creep_fwd_q, creep_rev_q, stall_move_q;
  logic [15:0] stall_tmo_q;
  logic        invert_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= RST_TOLERANCE;
      creep_thr_q  <= RST_CREEP_THRESH;
      fast_duty_q  <= RST_FAST_DUTY;
      creep_fwd_q  <= RST_CREEP_FWD;
      creep_rev_q  <= RST_CREEP_REV;
      stall_move_q <= RST_STALL_MOVE;
      stall_tmo_q  <= RST_STALL_TMO;
      invert_q     <= RST_INVERT_DIR;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_TOLERANCE:    tol_q        <= cfg_i.reg_data[7:0];
        REG_CREEP_THRESH: creep_thr_q  <= cfg_i.reg_data[10:0];
        REG_FAST_DUTY:    fast_duty_q  <= cfg_i.reg_data[7:0];
        REG_CREEP_FWD:    creep_fwd_q  <= cfg_i.reg_data[7:0];
        REG_CREEP_REV:    creep_rev_q  <= cfg_i.reg_data[7:0];
        REG_STALL_MOVE:   stall_move_q <= cfg_i.reg_data[7:0];
        REG_STALL_TMO:    stall_tmo_q  <= cfg_i.reg_data;
        REG_INVERT_DIR:   invert_q     <= cfg_i.reg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: input register feeds result register
  logic cmd_valid_q, res_valid_q;
  logic advance;

  assign advance    = cmd_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !cmd_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) cmd_valid_q <= in_i.valid;
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Input register (payload)
  logic [1:0]            act_q;
  logic [ANGLE_BITS-1:0] tgt_in_q, meas_q;
  logic [TMO_W-1:0]      tmo_q;
  logic [STEP_W-1:0]     step_q;
  logic                  fault_q, magnet_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      act_q    <= in_i.action;
      tgt_in_q <= in_i.target_angle;
      tmo_q    <= in_i.move_limit_ms;
      meas_q   <= in_i.measured_angle;
      step_q   <= in_i.time_step_ms;
      fault_q  <= in_i.driver_fault;
      magnet_q <= in_i.magnet_present;
    end
  end

  // Move state
  logic                  active_q, active_d;
  logic [ANGLE_BITS-1:0] target_q, target_d, ref_q, ref_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d, since_q, since_d;
  logic [TIMER_BITS-1:0] held_tmo_q, held_tmo_d;

  // Result values
  logic [DUTY_W-1:0]     duty_d;
  logic                  fwd_d, brake_d;
  status_e               status_d;
  logic [ANGLE_BITS-1:0] err_out_d;

  // Datapath terms
  logic [ANGLE_BITS-1:0] err, mv, mag, moved;
  logic                  forward;
  logic [SUM_W-1:0]      el_sum, sm_sum;
  logic [TIMER_BITS-1:0] el_sat, sm_sat, sm_new;
  logic [CMP_W-1:0]      tmo_ext;
  logic                  stall_hit, tmo_hit, within_tol, use_fast, moved_far;

  // Wrapped differences and their magnitudes
  assign err     = target_q - meas_q;
  assign mv      = meas_q - ref_q;
  assign mag     = err[ANGLE_BITS-1] ? (~err + 1'b1) : err;
  assign moved   = mv[ANGLE_BITS-1] ? (~mv + 1'b1) : mv;
  assign forward = !err[ANGLE_BITS-1] && (err != '0);

  // Saturating timers
  assign el_sum = SUM_W'(elapsed_q) + SUM_W'(step_q);
  assign sm_sum = SUM_W'(since_q) + SUM_W'(step_q);
  assign el_sat = (el_sum > TMR_MAX) ? {TIMER_BITS{1'b1}} : el_sum[TIMER_BITS-1:0];
  assign sm_sat = (sm_sum > TMR_MAX) ? {TIMER_BITS{1'b1}} : sm_sum[TIMER_BITS-1:0];

  // Threshold compares
  assign within_tol = MAG_W'(mag) <= MAG_W'(tol_q);
  assign use_fast   = MAG_W'(mag) > MAG_W'(creep_thr_q);
  assign moved_far  = MAG_W'(moved) > MAG_W'(stall_move_q);
  assign sm_new     = moved_far ? '0 : sm_sat;
  assign stall_hit  = CMP_W'(sm_new) > CMP_W'(stall_tmo_q);
  assign tmo_hit    = el_sat > held_tmo_q;
  assign tmo_ext    = CMP_W'(tmo_q);

  // Command evaluation
  always_comb begin
    active_d   = active_q;
    target_d   = target_q;
    ref_d      = ref_q;
    elapsed_d  = elapsed_q;
    since_d    = since_q;
    held_tmo_d = held_tmo_q;
    duty_d     = '0;
    fwd_d      = 1'b0;
    brake_d    = 1'b1;
    status_d   = ST_IDLE;
    err_out_d  = err;
    case (act_q)
      ACT_START: begin
        target_d   = tgt_in_q;
        held_tmo_d = tmo_ext[TIMER_BITS-1:0];
        ref_d      = meas_q;
        elapsed_d  = '0;
        since_d    = '0;
        active_d   = 1'b1;
        brake_d    = 1'b0;
        status_d   = ST_MOVING;
        err_out_d  = tgt_in_q - meas_q;
      end
      ACT_SAMPLE: begin
        if (active_q) begin
          elapsed_d = el_sat;
          since_d   = sm_sat;
          if (fault_q) begin
            status_d = ST_FAULT;
          end else if (!magnet_q) begin
            status_d = ST_MAGNET_LOST;
          end else if (within_tol) begin
            status_d = ST_REACHED;
          end else begin
            if (moved_far) ref_d = meas_q;
            since_d = sm_new;
            if (stall_hit) begin
              status_d = ST_STALL;
            end else if (tmo_hit) begin
              status_d = ST_TIMEOUT;
            end else begin
              status_d = ST_MOVING;
              brake_d  = 1'b0;
              duty_d   = use_fast ? fast_duty_q : (forward ? creep_fwd_q : creep_rev_q);
              fwd_d    = forward ^ invert_q;
            end
          end
          if (status_d != ST_MOVING) active_d = 1'b0;
        end
      end
      default: begin
        active_d = 1'b0;
      end
    endcase
  end

  // State update as each command is evaluated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      target_q   <= '0;
      ref_q      <= '0;
      elapsed_q  <= '0;
      since_q    <= '0;
      held_tmo_q <= '0;
    end else if (advance) begin
      active_q   <= active_d;
      target_q   <= target_d;
      ref_q      <= ref_d;
      elapsed_q  <= elapsed_d;
      since_q    <= since_d;
      held_tmo_q <= held_tmo_d;
    end
  end

  // Result register (payload)
  logic [DUTY_W-1:0]     res_duty_q;
  logic                  res_fwd_q, res_brake_q;
  status_e               res_status_q;
  logic [ANGLE_BITS-1:0] res_err_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_duty_q   <= duty_d;
      res_fwd_q    <= fwd_d;
      res_brake_q  <= brake_d;
      res_status_q <= status_d;
      res_err_q    <= err_out_d;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.drive_duty    = res_duty_q;
  assign out_o.drive_forward = res_fwd_q;
  assign out_o.brake_on      = res_brake_q;
  assign out_o.move_status   = res_status_q;
  assign out_o.angle_error   = res_err_q;

  // Checks
  `WPMC_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !res_valid_q, in_i.ready)
  `WPMC_ASSERT_NEXT(a_end_clears_active, clk_i, rst_ni,
    advance && (status_d != ST_MOVING), !active_q)
  `WPMC_ASSERT_NEXT(a_start_clears_timers, clk_i, rst_ni,
    advance && (act_q == ACT_START), (elapsed_q == '0) && (since_q == '0) && active_q)
  `WPMC_ASSERT_NOW(a_idle_sample_idle, clk_i, rst_ni,
    cmd_valid_q && !active_q && (act_q == ACT_SAMPLE), status_d == ST_IDLE)

endmodule

>>> tb/testbench.sv
// Self-checking bench for the wheel position move controller: directed rows,
// then random moves under several register settings, checked beat by beat.
// Depends on wpmc_pkg, the channel interfaces and the controller RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wpmc_pkg::*;

  localparam int ANG_W       = 12;
  localparam int TMR_W       = 16;
  localparam int DIR_ROWS    = 25;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_MAX   = 5000;
  localparam int SETTLE      = 6;
  localparam int RUN_BUDGET  = 285;

  // Spare action code; the block treats it like a stop
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]        act;
    logic [ANG_W-1:0]  tgt;
    logic [TMO_W-1:0]  tmo;
    logic [ANG_W-1:0]  meas;
    logic [STEP_W-1:0] step;
    logic              fault;
    logic              mag;
  } cmd_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic                    fwd;
    logic                    brake;
    logic [2:0]              st;
    logic signed [ANG_W-1:0] err;
  } res_t;

  typedef struct packed {
    cmd_t c;
    logic typed;
    res_t r;
  } row_t;

  typedef struct packed {
    logic [15:0] tol;
    logic [15:0] thr;
    logic [15:0] fast;
    logic [15:0] cfwd;
    logic [15:0] crev;
    logic [15:0] smv;
    logic [15:0] stmo;
    logic [15:0] inv;
  } reg_set_t;

  // Directed rows: reset settings (tolerance 3, creep below 35, fast 110,
  // creep 60, stall after 800 ms with no more than 2 counts of motion)
  localparam row_t DIR_TAB [DIR_ROWS] = '{
    // idle samples after reset: target 0, half turn, one count short
    '{'{ACT_SAMPLE, 0, 0, 0, 5, 0, 1},       1, '{0, 0, 1, ST_IDLE, 0}},
    '{'{ACT_SAMPLE, 0, 0, 2048, 5, 0, 1},    1, '{0, 0, 1, ST_IDLE, -2048}},
    '{'{ACT_SAMPLE, 0, 0, 4095, 0, 1, 0},    1, '{0, 0, 1, ST_IDLE, 1}},
    // start coasts whatever the flags say, then lands inside tolerance
    '{'{ACT_START, 4095, 65535, 0, 1023, 1, 0}, 1, '{0, 0, 0, ST_MOVING, -1}},
    '{'{ACT_SAMPLE, 0, 0, 0, 0, 0, 1},       1, '{0, 0, 1, ST_REACHED, -1}},
    // fast forward, then driver fault, then idle
    '{'{ACT_START, 1000, 500, 0, 0, 0, 1},   1, '{0, 0, 0, ST_MOVING, 1000}},
    '{'{ACT_SAMPLE, 0, 0, 0, 10, 0, 1},      1, '{110, 1, 0, ST_MOVING, 1000}},
    '{'{ACT_SAMPLE, 0, 0, 980, 10, 1, 1},    1, '{0, 0, 1, ST_FAULT, 20}},
    '{'{ACT_SAMPLE, 0, 0, 980, 10, 0, 1},    1, '{0, 0, 1, ST_IDLE, 20}},
    // lost magnet
    '{'{ACT_START, 1000, 500, 990, 0, 0, 1}, 1, '{0, 0, 0, ST_MOVING, 10}},
    '{'{ACT_SAMPLE, 0, 0, 990, 10, 0, 0},    1, '{0, 0, 1, ST_MAGNET_LOST, 10}},
    // reverse creep, then stop
    '{'{ACT_START, 100, 65535, 120, 0, 0, 1}, 1, '{0, 0, 0, ST_MOVING, -20}},
    '{'{ACT_SAMPLE, 0, 0, 120, 5, 0, 1},     1, '{60, 0, 0, ST_MOVING, -20}},
    '{'{ACT_STOP, 0, 0, 120, 5, 0, 1},       1, '{0, 0, 1, ST_IDLE, -20}},
    // no motion for a full second: stall
    '{'{ACT_START, 100, 65535, 80, 0, 0, 1}, 1, '{0, 0, 0, ST_MOVING, 20}},
    '{'{ACT_SAMPLE, 0, 0, 80, 1023, 0, 1},   1, '{0, 0, 1, ST_STALL, 20}},
    // half-turn error and overall timeout
    '{'{ACT_START, 2048, 5, 0, 0, 0, 1},     1, '{0, 0, 0, ST_MOVING, -2048}},
    '{'{ACT_SAMPLE, 0, 0, 0, 6, 0, 1},       1, '{0, 0, 1, ST_TIMEOUT, -2048}},
    // spare action code ends the move
    '{'{ACT_START, 500, 65535, 400, 0, 0, 1}, 1, '{0, 0, 0, ST_MOVING, 100}},
    '{'{ACT_NONE, 0, 0, 400, 0, 0, 1},       1, '{0, 0, 1, ST_IDLE, 100}},
    '{'{ACT_SAMPLE, 0, 0, 450, 0, 0, 1},     1, '{0, 0, 1, ST_IDLE, 50}},
    // stall reference moves on motion, then the timer runs out
    '{'{ACT_START, 1000, 65535, 0, 0, 0, 1}, 1, '{0, 0, 0, ST_MOVING, 1000}},
    '{'{ACT_SAMPLE, 0, 0, 3, 700, 0, 1},     0, '0},
    '{'{ACT_SAMPLE, 0, 0, 5, 700, 0, 1},     0, '0},
    '{'{ACT_SAMPLE, 0, 0, 5, 101, 0, 1},     0, '0}
  };

  logic clk;
  logic rst_n;

  wpmc_in_if  #(.ANGLE_BITS(ANG_W)) cmd_if ();
  wpmc_out_if #(.ANGLE_BITS(ANG_W)) res_if ();
  wpmc_cfg_if                       cfg_if ();

  wheel_position_move_controller #(
    .ANGLE_BITS(ANG_W),
    .TIMER_BITS(TMR_W)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_if.sink),
    .out_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  // Controller copy: tuning registers
  logic [7:0]  tol_r       = RST_TOLERANCE;
  logic [10:0] creep_thr_r = RST_CREEP_THRESH;
  logic [7:0]  fast_r      = RST_FAST_DUTY;
  logic [7:0]  creep_fwd_r = RST_CREEP_FWD;
  logic [7:0]  creep_rev_r = RST_CREEP_REV;
  logic [7:0]  stall_mv_r  = RST_STALL_MOVE;
  logic [15:0] stall_tmo_r = RST_STALL_TMO;
  logic        invert_r    = RST_INVERT_DIR;

  // Controller copy: move state
  logic             move_on   = 1'b0;
  logic [ANG_W-1:0] tgt_q     = '0;
  logic [ANG_W-1:0] ref_ang   = '0;
  logic [TMR_W-1:0] elapsed_q = '0;
  logic [TMR_W-1:0] still_ms  = '0;
  logic [TMR_W-1:0] limit_ms  = '0;

  res_t due_results [$];
  int   fail_count = 0;
  int   beat_no    = 0;
  bit   gaps_on    = 1'b1;
  bit   hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net on the whole run
  initial begin
    #2_500_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Wrapped difference a - b over one turn
  function automatic logic signed [ANG_W-1:0] wrap_err(logic [ANG_W-1:0] a,
                                                      logic [ANG_W-1:0] b);
    logic [ANG_W-1:0] d;
    d = a - b;
    return signed'(d);
  endfunction

  function automatic logic [TMR_W-1:0] sat_add(logic [TMR_W-1:0] t,
                                               logic [STEP_W-1:0] s);
    logic [TMR_W:0] sum;
    sum = {1'b0, t} + s;
    return sum[TMR_W] ? '1 : sum[TMR_W-1:0];
  endfunction

  // Controller behavior for one command; updates the copied state
  function automatic res_t control_step(cmd_t c);
    res_t r;
    int mag;
    int moved;
    logic signed [ANG_W-1:0] e;
    logic signed [ANG_W-1:0] mv;
    r = '0;
    r.brake = 1'b1;
    r.st = ST_IDLE;
    if (c.act == ACT_START) begin
      tgt_q = c.tgt;
      limit_ms = c.tmo;
      ref_ang = c.meas;
      elapsed_q = '0;
      still_ms = '0;
      move_on = 1'b1;
      r.brake = 1'b0;
      r.st = ST_MOVING;
    end else if (c.act == ACT_SAMPLE && move_on) begin
      elapsed_q = sat_add(elapsed_q, c.step);
      still_ms = sat_add(still_ms, c.step);
      e = wrap_err(tgt_q, c.meas);
      mag = (e < 0) ? -int'(e) : int'(e);
      if (c.fault) begin
        r.st = ST_FAULT;
      end else if (!c.mag) begin
        r.st = ST_MAGNET_LOST;
      end else if (mag <= tol_r) begin
        r.st = ST_REACHED;
      end else begin
        // enough motion restarts the stall timer from here
        mv = wrap_err(c.meas, ref_ang);
        moved = (mv < 0) ? -int'(mv) : int'(mv);
        if (moved > stall_mv_r) begin
          ref_ang = c.meas;
          still_ms = '0;
        end
        if (still_ms > stall_tmo_r) begin
          r.st = ST_STALL;
        end else if (elapsed_q > limit_ms) begin
          r.st = ST_TIMEOUT;
        end else begin
          r.st = ST_MOVING;
          r.brake = 1'b0;
          r.duty = (mag > creep_thr_r) ? fast_r : ((e > 0) ? creep_fwd_r : creep_rev_r);
          r.fwd = (e > 0) ^ invert_r;
        end
      end
      if (r.st != ST_MOVING) move_on = 1'b0;
    end else if (c.act != ACT_SAMPLE) begin
      move_on = 1'b0;
    end
    r.err = wrap_err(tgt_q, c.meas);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // One command beat; expectation is queued at the accepting edge
  task automatic issue_cmd(input cmd_t c, input logic typed = 1'b0,
                           input res_t typed_res = '0);
    res_t pred;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 37) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid           <= 1'b1;
    cmd_if.action          <= c.act;
    cmd_if.target_angle    <= c.tgt;
    cmd_if.move_limit_ms   <= c.tmo;
    cmd_if.measured_angle  <= c.meas;
    cmd_if.time_step_ms    <= c.step;
    cmd_if.driver_fault    <= c.fault;
    cmd_if.magnet_present  <= c.mag;
    do @(posedge clk); while (!cmd_if.ready);
    pred = control_step(c);
    due_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.reg_data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_TOLERANCE:    tol_r = d[7:0];
      REG_CREEP_THRESH: creep_thr_r = d[10:0];
      REG_FAST_DUTY:    fast_r = d[7:0];
      REG_CREEP_FWD:    creep_fwd_r = d[7:0];
      REG_CREEP_REV:    creep_rev_r = d[7:0];
      REG_STALL_MOVE:   stall_mv_r = d[7:0];
      REG_STALL_TMO:    stall_tmo_r = d[15:0];
      REG_INVERT_DIR:   invert_r = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_regs(input reg_set_t s);
    write_reg(REG_TOLERANCE, s.tol);
    write_reg(REG_CREEP_THRESH, s.thr);
    write_reg(REG_FAST_DUTY, s.fast);
    write_reg(REG_CREEP_FWD, s.cfwd);
    write_reg(REG_CREEP_REV, s.crev);
    write_reg(REG_STALL_MOVE, s.smv);
    write_reg(REG_STALL_TMO, s.stmo);
    write_reg(REG_INVERT_DIR, s.inv);
  endtask

  // Stop offering, wait out every pending result, let the pipe settle
  task automatic drain();
    int guard;
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    guard = 0;
    while (due_results.size() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly whole moves (start, samples closing in on the target, now and
  // then a stop); the rest is noise. Long runs push both timers to saturation.
  task automatic run_moves(input int budget, input bit long_runs);
    cmd_t c;
    int n, k, pick, span, delta;
    bit marathon;
    logic [ANG_W-1:0] aim, cur;
    logic signed [ANG_W-1:0] e;
    n = 0;
    while (n < budget) begin
      pick = $urandom_range(99);
      c.act = 2'($urandom);
      c.tgt = ANG_W'($urandom);
      c.tmo = TMO_W'($urandom);
      c.meas = ANG_W'($urandom);
      c.step = STEP_W'($urandom);
      c.fault = 1'($urandom);
      c.mag = 1'($urandom);
      if (pick < 10) begin
        issue_cmd(c);
        n++;
      end else begin
        marathon = long_runs && pick < 13;
        aim = ANG_W'($urandom);
        c.act = ACT_START;
        c.tgt = aim;
        pick = $urandom_range(99);
        if (pick < 50) c.tmo = TMO_W'($urandom_range(200, 5000));
        else if (pick < 70) c.tmo = TMO_W'($urandom_range(100));
        else if (pick < 85) c.tmo = '1;
        else if (pick < 92) c.tmo = 16'hFFFE;
        if (marathon) c.tmo = $urandom_range(1) ? 16'hFFFF : 16'hFFFE;
        if ($urandom_range(99) < 40) cur = ANG_W'($urandom);
        else cur = aim + 12'($urandom_range(400)) - 12'd200;
        if (marathon) cur = aim + 12'd1000;
        c.meas = cur;
        issue_cmd(c);
        n++;
        k = 0;
        while (move_on && n < budget && k < (marathon ? 80 : 60)) begin
          c.act = ACT_SAMPLE;
          c.tgt = ANG_W'($urandom);
          c.tmo = TMO_W'($urandom);
          if (marathon) begin
            // parked off target with the longest steps
            c.step = '1;
            c.fault = 1'b0;
            c.mag = 1'b1;
          end else begin
            e = wrap_err(aim, cur);
            span = (e < 0) ? -int'(e) : int'(e);
            pick = $urandom_range(99);
            if (pick < 70) delta = $urandom_range(span / 3 + 4);
            else if (pick < 85) delta = 0;
            else if (pick < 95) delta = $urandom_range(6) - 3;
            else delta = $urandom_range(4095);
            cur = (e < 0) ? cur - 12'(delta) : cur + 12'(delta);
            pick = $urandom_range(99);
            if (pick < 85) c.step = STEP_W'($urandom_range(40));
            else if (pick < 97) c.step = STEP_W'($urandom_range(41, 400));
            else c.step = STEP_W'($urandom_range(401, 1023));
            c.fault = $urandom_range(99) < 2;
            c.mag = $urandom_range(99) >= 2;
          end
          c.meas = cur;
          issue_cmd(c);
          n++;
          k++;
        end
        if (n < budget && $urandom_range(99) < 20) begin
          c.act = $urandom_range(1) ? ACT_STOP : ACT_SAMPLE;
          c.meas = ANG_W'($urandom);
          issue_cmd(c);
          n++;
        end
      end
    end
  endtask

  // Result side ready: random stalls, or a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        res_if.ready <= !(gaps_on && $urandom_range(99) < 37);
      end
    end
  end

  // Compare every result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing pending", beat_no));
      end else begin
        want = due_results.pop_front();
        if (res_if.drive_duty !== want.duty)
          report_mismatch($sformatf("beat %0d drive_duty %0d, want %0d",
                                    beat_no, res_if.drive_duty, want.duty));
        if (res_if.drive_forward !== want.fwd)
          report_mismatch($sformatf("beat %0d drive_forward %0b, want %0b",
                                    beat_no, res_if.drive_forward, want.fwd));
        if (res_if.brake_on !== want.brake)
          report_mismatch($sformatf("beat %0d brake_on %0b, want %0b",
                                    beat_no, res_if.brake_on, want.brake));
        if (res_if.move_status !== want.st)
          report_mismatch($sformatf("beat %0d move_status %0d, want %0d",
                                    beat_no, res_if.move_status, want.st));
        if (res_if.angle_error !== want.err)
          report_mismatch($sformatf("beat %0d angle_error %0d, want %0d",
                                    beat_no, res_if.angle_error, want.err));
      end
      beat_no++;
    end
  end

  initial begin : stimulus
    reg_set_t s;
    rst_n                  = 1'b0;
    cmd_if.valid           = 1'b0;
    cmd_if.action          = ACT_STOP;
    cmd_if.target_angle    = '0;
    cmd_if.move_limit_ms   = '0;
    cmd_if.measured_angle  = '0;
    cmd_if.time_step_ms    = '0;
    cmd_if.driver_fault    = 1'b0;
    cmd_if.magnet_present  = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.reg_index       = REG_TOLERANCE;
    cfg_if.reg_data        = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows on reset settings
    for (int i = 0; i < DIR_ROWS; i++)
      issue_cmd(DIR_TAB[i].c, DIR_TAB[i].typed, DIR_TAB[i].r);
    drain();

    // Random tuning; result side holds off while commands keep coming
    s.tol  = 16'($urandom_range(40));
    s.thr  = 16'($urandom_range(300));
    s.fast = 16'($urandom_range(255));
    s.cfwd = 16'($urandom_range(255));
    s.crev = 16'($urandom_range(255));
    s.smv  = 16'($urandom_range(10));
    s.stmo = 16'($urandom_range(50, 3000));
    s.inv  = 16'($urandom_range(1));
    program_regs(s);
    hold_req = 1'b1;
    run_moves(RUN_BUDGET, 1'b0);
    drain();

    // Everything at its minimum
    program_regs('0);
    run_moves(RUN_BUDGET, 1'b0);
    drain();

    // Everything at its maximum, no idling on either side
    program_regs('{255, 2047, 255, 255, 255, 255, 65535, 1});
    gaps_on = 1'b0;
    run_moves(RUN_BUDGET, 1'b1);
    drain();
    gaps_on = 1'b1;

    // Full 16-bit write data; unused upper bits must be dropped
    s.tol  = 16'($urandom);
    s.thr  = 16'($urandom);
    s.fast = 16'($urandom);
    s.cfwd = 16'($urandom);
    s.crev = 16'($urandom);
    s.smv  = 16'($urandom);
    s.stmo = 16'($urandom);
    s.inv  = 16'($urandom);
    program_regs(s);
    hold_req = 1'b1;
    run_moves(RUN_BUDGET, 1'b0);
    drain();

    // Defaults again with the bridge direction inverted
    program_regs('{16'(RST_TOLERANCE), 16'(RST_CREEP_THRESH), 16'(RST_FAST_DUTY),
                   16'(RST_CREEP_FWD), 16'(RST_CREEP_REV), 16'(RST_STALL_MOVE),
                   RST_STALL_TMO, 16'd1});
    run_moves(RUN_BUDGET, 1'b0);
    drain();

    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
